@@ sv/kmd_pkg.sv @@
// kmd_pkg: shared field widths, reset constants and the event batch type
// for the key matrix debounce scanner
// no dependencies
package kmd_pkg;

   localparam int ROW_W    = 2;   // row_index field
   localparam int LVL_W    = 4;   // column_levels field
   localparam int TIME_W   = 32;  // now_ms, change times, debounce setting
   localparam int KEY_W    = 4;   // key_index field
   localparam int MAP_W    = 16;  // pressed_map field
   localparam int MAX_COLS = 16;  // widest column count the batch type carries

   localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;

   // one evaluated row request handed to the event serializer
   typedef struct packed {
      logic [MAX_COLS-1:0] hit;      // columns whose change was accepted
      logic [MAX_COLS-1:0] pressed;  // new debounced level per column
      logic [ROW_W-1:0]    row;
      logic [MAP_W-1:0]    map;      // pressed map before this row's events
   } batch_type;

endpackage

@@ sv/key_matrix_debounce_scanner.sv @@
// key_matrix_debounce_scanner: top level of the 4x4 key matrix scanner with
// per-key debounce; uses kmd_pkg, kmd_row_mem and kmd_emit
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_ready  | row_index, column_levels, now_ms
//   rsp     | out       | rsp_valid/rsp_ready  | key_index, key_pressed, last_event,
//           |           |                      | pressed_map
//   csr     | in        | csr_write_en         | debounce_ms
//
// a request is taken into the evaluate stage while the change time memory
// is read; there it is evaluated, and a row with accepted changes is handed
// to the event serializer. a row with n accepted changes shows n events on
// the result port (n up to COLS); a row with none retires at once, so
// requests flow one per cycle while no events are pending.
// synchronous reset clears key states, memory row valid bits (unwritten
// rows read as time zero) and sets debounce_ms to 50; there is no clear pass.
// a stalled result port backs up into the evaluate stage and then req_ready.
module key_matrix_debounce_scanner #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kmd_pkg::ROW_W-1:0]     req_row_index,
   input  logic [kmd_pkg::LVL_W-1:0]     req_column_levels,
   input  logic [kmd_pkg::TIME_W-1:0]    req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kmd_pkg::KEY_W-1:0]     rsp_key_index,
   output logic                          rsp_key_pressed,
   output logic                          rsp_last_event,
   output logic [kmd_pkg::MAP_W-1:0]     rsp_pressed_map,
   input  logic                          csr_write_en,
   input  logic [kmd_pkg::TIME_W-1:0]    csr_write_data
);

   localparam int KEY_COUNT = ROWS * COLS;
   localparam int ADDR_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int KIDX_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int DATA_W    = COLS * kmd_pkg::TIME_W;

   // configuration
   logic [kmd_pkg::TIME_W-1:0] csr_debounce_ff;

   // evaluate stage
   logic                        s1_valid_ff;
   logic                        s1_inrange_ff;
   logic [kmd_pkg::ROW_W-1:0]   s1_row_ff;
   logic [kmd_pkg::LVL_W-1:0]   s1_levels_ff;
   logic [kmd_pkg::TIME_W-1:0]  s1_now_ff;

   // debounced key states
   logic [KEY_COUNT-1:0]        key_state_ff;
   logic [KEY_COUNT-1:0]        key_state_in;

   logic                        req_take;
   logic [ADDR_W-1:0]           rd_addr;
   logic [DATA_W-1:0]           rd_data;
   logic [DATA_W-1:0]           wr_data;
   logic                        mem_we;
   logic [COLS-1:0]             hit_in;
   logic [COLS-1:0]             press_in;
   logic                        s1_has;
   logic                        s1_go;
   logic                        emit_free;
   kmd_pkg::batch_type          batch;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_debounce_ff <= kmd_pkg::DEBOUNCE_RESET;
      end else if (csr_write_en) begin
         csr_debounce_ff <= csr_write_data;
      end
   end

   // request handshake: the evaluate stage frees up when it retires
   assign req_take = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_inrange_ff <= (int'(req_row_index) < ROWS);
         s1_row_ff     <= req_row_index;
         s1_levels_ff  <= req_column_levels;
         s1_now_ff     <= req_now_ms;
      end
   end

   // the read address follows the request that will sit in the evaluate
   // stage next cycle, so a stalled request keeps re-reading its own row
   assign rd_addr = req_take ? ADDR_W'(req_row_index) : ADDR_W'(s1_row_ff);

   kmd_row_mem #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr_en   (mem_we),
      .wr_addr (ADDR_W'(s1_row_ff)),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // per-column lanes: level change against debounced state, then the
   // wrapping elapsed time against the debounce setting
   always_comb begin
      logic                       lvl;
      logic                       pressed;
      logic [kmd_pkg::TIME_W-1:0] elapsed;
      logic [KIDX_W-1:0]          k;
      hit_in       = '0;
      press_in     = '0;
      key_state_in = key_state_ff;
      wr_data      = rd_data;
      for (int c = 0; c < COLS; c++) begin
         // columns past the field width read as released
         lvl = 1'b1;
         if (c < kmd_pkg::LVL_W) begin
            lvl = s1_levels_ff[2'(c)];
         end
         pressed     = !lvl;
         k           = KIDX_W'(int'(s1_row_ff) * COLS + c);
         elapsed     = s1_now_ff - rd_data[c*kmd_pkg::TIME_W +: kmd_pkg::TIME_W];
         press_in[c] = pressed;
         hit_in[c]   = s1_inrange_ff && (pressed != key_state_ff[k]) &&
                       (elapsed > csr_debounce_ff);
         if (hit_in[c]) begin
            key_state_in[k] = pressed;
            wr_data[c*kmd_pkg::TIME_W +: kmd_pkg::TIME_W] = s1_now_ff;
         end
      end
   end

   assign s1_has = |hit_in;
   // a row without events retires at once; one with events waits for the
   // serializer to drain the previous row
   assign s1_go  = s1_valid_ff && (!s1_has || emit_free);
   assign mem_we = s1_go && s1_has;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_state_ff <= '0;
      end else if (s1_go) begin
         key_state_ff <= key_state_in;
      end
   end

   // batch for the serializer: map as it stands before this row's events
   always_comb begin
      batch         = '0;
      batch.row     = s1_row_ff;
      for (int c = 0; c < COLS; c++) begin
         batch.hit[c]     = hit_in[c];
         batch.pressed[c] = press_in[c];
      end
      for (int i = 0; i < kmd_pkg::MAP_W; i++) begin
         if (i < KEY_COUNT) begin
            batch.map[i] = key_state_ff[i];
         end
      end
   end

   kmd_emit #(
      .COLS (COLS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (mem_we),
      .batch           (batch),
      .free            (emit_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_index   (rsp_key_index),
      .rsp_key_pressed (rsp_key_pressed),
      .rsp_last_event  (rsp_last_event),
      .rsp_pressed_map (rsp_pressed_map)
   );

   // a loaded row always shows an event next cycle
   a_load_shows_event: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> rsp_valid)
      else $error("row with accepted changes produced no event");

   // key states only move when a row retires
   a_state_only_on_retire: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(key_state_ff))
      else $error("key state changed without a retiring row");

   // a row index beyond the matrix never yields a change
   a_out_of_range_quiet: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_inrange_ff) |-> (hit_in == '0))
      else $error("out of range row produced a key change");

   // a new row never overwrites a serializer that still has events
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (!rsp_valid || (rsp_ready && rsp_last_event)))
      else $error("serializer loaded while events were pending");

endmodule

@@ sv/kmd_row_mem.sv @@
// kmd_row_mem: change time memory, one row of column times per entry,
// with row valid bits and write-to-read forwarding; uses kmd_pkg
module kmd_row_mem #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr,
   input  logic                                   wr_en,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_addr,
   input  logic [COLS*kmd_pkg::TIME_W-1:0]        wr_data,
   output logic [COLS*kmd_pkg::TIME_W-1:0]        rd_data
);

   localparam int DATA_W = COLS * kmd_pkg::TIME_W;

   logic [DATA_W-1:0] ram [ROWS];
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [ROWS-1:0]   valid_ff;
   logic              rv_ff;
   logic              fwd_ff;
   logic              same_row;

   assign same_row = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      q_ff     <= ram[rd_addr];
      wdata_ff <= wr_data;
   end

   // a row never written reads as all zero times
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rv_ff    <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rv_ff  <= valid_ff[rd_addr] | same_row;
         fwd_ff <= same_row;
      end
   end

   assign rd_data = !rv_ff ? '0 : (fwd_ff ? wdata_ff : q_ff);

endmodule

@@ sv/kmd_emit.sv @@
// kmd_emit: serializes the accepted key changes of one row, lowest column
// first, and tracks the running pressed map; uses kmd_pkg
module kmd_emit #(
   parameter int COLS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  kmd_pkg::batch_type          batch,
   output logic                        free,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [kmd_pkg::KEY_W-1:0]   rsp_key_index,
   output logic                        rsp_key_pressed,
   output logic                        rsp_last_event,
   output logic [kmd_pkg::MAP_W-1:0]   rsp_pressed_map
);

   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

   logic [COLS-1:0]              hit_ff;
   logic [COLS-1:0]              pressed_ff;
   logic [kmd_pkg::ROW_W-1:0]    row_ff;
   logic [kmd_pkg::MAP_W-1:0]    map_ff;
   logic [COL_W-1:0]             sel;
   logic [COLS-1:0]              sel_mask;
   logic [kmd_pkg::MAP_W-1:0]    map_in;
   logic                         take;

   // lowest pending column and the event it makes
   always_comb begin
      int  full;
      logic found;
      sel    = '0;
      found  = 1'b0;
      for (int c = 0; c < COLS; c++) begin
         if (hit_ff[c] && !found) begin
            sel   = COL_W'(c);
            found = 1'b1;
         end
      end
      sel_mask      = '0;
      sel_mask[sel] = 1'b1;
      full          = int'(row_ff) * COLS + int'(sel);
      map_in        = map_ff;
      if (full < kmd_pkg::MAP_W) begin
         map_in[kmd_pkg::KEY_W'(full)] = pressed_ff[sel];
      end
      rsp_key_index = kmd_pkg::KEY_W'(full);
   end

   assign rsp_valid       = |hit_ff;
   assign rsp_key_pressed = pressed_ff[sel];
   assign rsp_last_event  = ((hit_ff & ~sel_mask) == '0);
   assign rsp_pressed_map = map_in;
   assign take            = rsp_valid && rsp_ready;
   assign free            = !rsp_valid || (take && rsp_last_event);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else if (load) begin
         hit_ff <= batch.hit[COLS-1:0];
      end else if (take) begin
         hit_ff <= hit_ff & ~sel_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pressed_ff <= batch.pressed[COLS-1:0];
         row_ff     <= batch.row;
         map_ff     <= batch.map;
      end else if (take) begin
         map_ff     <= map_in;
      end
   end

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for key_matrix_debounce_scanner, a directed table
// followed by random debounce phases, all checked by a per-key debounce predictor
// depends on kmd_pkg and key_matrix_debounce_scanner
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS          = 4;
   localparam int COLS          = 4;
   localparam int SETTLE_CYCLES = 8;       // row requests with no events still in flight
   localparam int LONG_HOLD     = 400;     // result port held off to back up req_ready
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 70;
   localparam int DIRECTED_ROWS = 22;

   typedef logic [kmd_pkg::ROW_W-1:0]  row_type;
   typedef logic [kmd_pkg::LVL_W-1:0]  lvl_type;
   typedef logic [kmd_pkg::TIME_W-1:0] time_type;
   typedef logic [kmd_pkg::KEY_W-1:0]  key_type;
   typedef logic [kmd_pkg::MAP_W-1:0]  map_type;

   // one key event as it leaves the result port
   typedef struct packed {
      key_type          key;
      logic             pressed;
      logic             last_flag;
      map_type          map;
   } key_event_type;

   typedef enum logic [0:0] {STEP_SAMPLE, STEP_CSR} step_kind_type;

   // directed table entry: a row request or a debounce write; where typed is
   // set, the event count and final pressed map are written in by hand
   typedef struct packed {
      step_kind_type     kind;
      row_type           row;
      lvl_type           lvl;
      time_type          value;     // now_ms, or debounce_ms for a write
      logic              typed;
      logic [2:0]        n_events;
      map_type           map;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   row_type             req_row_index = '0;
   lvl_type             req_column_levels = '1;
   time_type            req_now_ms = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   key_type             rsp_key_index;
   logic                rsp_key_pressed;
   logic                rsp_last_event;
   map_type             rsp_pressed_map;
   logic                csr_write_en = 1'b0;
   time_type            csr_write_data = '0;

   // predictor state: debounced keys, last accepted change time, debounce setting
   map_type             held_keys = '0;
   time_type            last_change_ms [ROWS*COLS];
   time_type            hold_off_ms = kmd_pkg::DEBOUNCE_RESET;
   key_event_type       pending_events [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  samples_sent = 0;
   int  events_seen = 0;
   int  settings_used = 0;
   int  req_stall_cycles = 0;
   bit  req_calm = 1'b0;     // sender runs back to back while set
   bit  rsp_calm = 1'b0;     // receiver takes every event while set
   bit  starve_rsp = 1'b0;   // asks the receiver for one long hold-off

   // hand-checked opening sequence; debounce is 50 after reset
   stim_row_type directed [DIRECTED_ROWS] = '{
      '{STEP_SAMPLE, 2'd0, 4'b0000, 32'd0,          1'b1, 3'd0, 16'h0000}, // just out of reset
      '{STEP_SAMPLE, 2'd0, 4'b0000, 32'd50,         1'b1, 3'd0, 16'h0000}, // age equals debounce
      '{STEP_SAMPLE, 2'd0, 4'b0000, 32'd51,         1'b1, 3'd4, 16'h000F},
      '{STEP_SAMPLE, 2'd1, 4'b1010, 32'd100,        1'b1, 3'd2, 16'h005F},
      '{STEP_SAMPLE, 2'd0, 4'b1111, 32'd101,        1'b1, 3'd0, 16'h0000}, // bounce rejected
      '{STEP_SAMPLE, 2'd0, 4'b1111, 32'd102,        1'b1, 3'd4, 16'h0050},
      '{STEP_SAMPLE, 2'd3, 4'b0000, 32'hFFFF_FFFF,  1'b1, 3'd4, 16'hF050}, // top of time
      '{STEP_SAMPLE, 2'd3, 4'b1111, 32'd49,         1'b1, 3'd0, 16'h0000}, // wrapped age 50
      '{STEP_SAMPLE, 2'd3, 4'b1111, 32'd50,         1'b1, 3'd4, 16'h0050}, // wrapped age 51
      '{STEP_SAMPLE, 2'd2, 4'b0110, 32'd200,        1'b1, 3'd2, 16'h0950},
      '{STEP_SAMPLE, 2'd2, 4'b0110, 32'd300,        1'b1, 3'd0, 16'h0000}, // no change
      '{STEP_SAMPLE, 2'd1, 4'b1111, 32'd300,        1'b1, 3'd2, 16'h0900},
      '{STEP_SAMPLE, 2'd2, 4'b1001, 32'd400,        1'b1, 3'd4, 16'h0600}, // mixed press/release
      '{STEP_CSR,    2'd0, 4'b0000, 32'd0,          1'b0, 3'd0, 16'h0000}, // no debounce
      '{STEP_SAMPLE, 2'd0, 4'b1110, 32'd400,        1'b1, 3'd1, 16'h0601},
      '{STEP_SAMPLE, 2'd0, 4'b1111, 32'd400,        1'b1, 3'd0, 16'h0000}, // zero age
      '{STEP_SAMPLE, 2'd0, 4'b1111, 32'd401,        1'b1, 3'd1, 16'h0600},
      '{STEP_CSR,    2'd0, 4'b0000, 32'hFFFF_FFFF,  1'b0, 3'd0, 16'h0000}, // nothing can pass
      '{STEP_SAMPLE, 2'd1, 4'b0000, 32'h8000_0000,  1'b1, 3'd0, 16'h0000},
      '{STEP_SAMPLE, 2'd2, 4'b1111, 32'h7FFF_FFFF,  1'b1, 3'd0, 16'h0000},
      '{STEP_CSR,    2'd0, 4'b0000, 32'd50,         1'b0, 3'd0, 16'h0000}, // back to reset value
      '{STEP_SAMPLE, 2'd2, 4'b1111, 32'h8000_0000,  1'b1, 3'd2, 16'h0000}
   };

   key_matrix_debounce_scanner #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row_index     (req_row_index),
      .req_column_levels (req_column_levels),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_index     (rsp_key_index),
      .rsp_key_pressed   (rsp_key_pressed),
      .rsp_last_event    (rsp_last_event),
      .rsp_pressed_map   (rsp_pressed_map),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycle count, input stall count and run timeout
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && !req_ready) begin
         req_stall_cycles++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events still pending",
                  cycle_count, pending_events.size());
         $display("key_matrix_debounce_scanner: mismatch");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // per-item idle gap; calm stretches with no gaps come and go at random
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 29) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : int'($urandom_range(0, 19));
   endfunction

   // debounce evaluation of one row request: queues the key events it causes
   // and updates the predicted key states and change times
   function automatic int scan_row_events(input row_type row,
                                          input lvl_type lvl,
                                          input time_type now,
                                          output map_type map_after);
      key_event_type     found [COLS];
      int                count;
      int                k;
      logic              down;
      time_type          age;
      count = 0;
      map_after = held_keys;
      if (int'(row) >= ROWS) begin
         return 0;
      end
      for (int c = 0; c < COLS; c++) begin
         k = int'(row) * COLS + c;
         // columns past the field read released
         down = (c < kmd_pkg::LVL_W) ? !lvl[c] : 1'b0;
         age = now - last_change_ms[k];          // wraps mod 2^32
         if (down != held_keys[k] && age > hold_off_ms) begin
            held_keys[k] = down;
            last_change_ms[k] = now;
            found[count].key = key_type'(k);
            found[count].pressed = down;
            found[count].last_flag = 1'b0;
            found[count].map = held_keys;
            count++;
         end
      end
      if (count > 0) begin
         found[count-1].last_flag = 1'b1;
         map_after = held_keys;
      end
      for (int i = 0; i < count; i++) begin
         pending_events.push_back(found[i]);
      end
      return count;
   endfunction

   // offer one row request after a random gap; predicts at the accepting edge
   task automatic offer_sample(input row_type row, input lvl_type lvl,
                               input time_type now, output int count,
                               output map_type map_after);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_index <= row;
      req_column_levels <= lvl;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      count = scan_row_events(row, lvl, now, map_after);
      samples_sent++;
   endtask

   // idle the request side until every event is out and the pipe is empty
   task automatic drain_events();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // debounce register is only written while the block is idle
   task automatic set_debounce(input time_type value);
      drain_events();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      hold_off_ms = value;
      settings_used++;
      csr_write_en <= 1'b0;
   endtask

   // result side: random ready gaps, one long hold-off on request, field checks
   initial begin
      int            gap;
      key_event_type want;
      while (reset) @(posedge clock);
      forever begin
         if (starve_rsp) begin
            gap = LONG_HOLD;
            starve_rsp = 1'b0;
         end else begin
            gap = draw_gap(rsp_calm);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         events_seen++;
         if (pending_events.size() == 0) begin
            flag_error($sformatf("event for key %0d with nothing pending", rsp_key_index));
         end else begin
            want = pending_events.pop_front();
            if (rsp_key_index !== want.key) begin
               flag_error($sformatf("key_index got %0d want %0d", rsp_key_index, want.key));
            end
            if (rsp_key_pressed !== want.pressed) begin
               flag_error($sformatf("key_pressed got %0b want %0b key %0d",
                                    rsp_key_pressed, want.pressed, want.key));
            end
            if (rsp_last_event !== want.last_flag) begin
               flag_error($sformatf("last_event got %0b want %0b key %0d",
                                    rsp_last_event, want.last_flag, want.key));
            end
            if (rsp_pressed_map !== want.map) begin
               flag_error($sformatf("pressed_map got 0x%04h want 0x%04h key %0d",
                                    rsp_pressed_map, want.map, want.key));
            end
         end
      end
   end

   // request side: reset, directed table, then random debounce phases
   initial begin
      int                count;
      map_type           map_after;
      time_type          phase_debounce [PHASES];
      time_type          clock_ms;
      time_type          span;
      lvl_type           last_lvl [ROWS];
      row_type           row;
      lvl_type           lvl;
      time_type          now;

      foreach (last_change_ms[k]) last_change_ms[k] = '0;
      foreach (last_lvl[r]) last_lvl[r] = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, hand values checked against the predictor
      foreach (directed[i]) begin
         if (directed[i].kind == STEP_CSR) begin
            set_debounce(directed[i].value);
         end else begin
            offer_sample(directed[i].row, directed[i].lvl, directed[i].value,
                         count, map_after);
            if (directed[i].typed && count != int'(directed[i].n_events)) begin
               flag_error($sformatf("table row %0d: %0d events predicted, %0d typed",
                                    i, count, directed[i].n_events));
            end
            if (directed[i].typed && count > 0 && map_after !== directed[i].map) begin
               flag_error($sformatf("table row %0d: map 0x%04h predicted, 0x%04h typed",
                                    i, map_after, directed[i].map));
            end
         end
      end

      // random phases: mostly time moving forward with bouncing rows, some noise
      phase_debounce = '{32'd0, 32'd3, 32'd17, kmd_pkg::DEBOUNCE_RESET,
                         time_type'($urandom_range(0, 40)), time_type'($urandom)};
      for (int p = 0; p < PHASES; p++) begin
         set_debounce(phase_debounce[p]);
         clock_ms = $urandom;
         span = (phase_debounce[p] < 1000) ? phase_debounce[p] * 2 + 4 : 32'hFFFF_FFFF;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // back up the block while the sender keeps going
            if (p == 1 && i == 5) begin
               starve_rsp = 1'b1;
            end
            if ($urandom_range(0, 99) < 15) begin
               row = row_type'($urandom);
               lvl = lvl_type'($urandom);
               now = $urandom;
            end else begin
               row = row_type'($urandom_range(0, ROWS - 1));
               if ($urandom_range(0, 1) == 1) begin
                  lvl = last_lvl[row] ^
                        lvl_type'(1 << $urandom_range(0, kmd_pkg::LVL_W - 1));
               end else begin
                  lvl = lvl_type'($urandom);
               end
               last_lvl[row] = lvl;
               clock_ms = clock_ms + $urandom_range(0, span);
               now = clock_ms;
            end
            offer_sample(row, lvl, now, count, map_after);
         end
      end

      drain_events();
      $display("covered %0d row requests and %0d key events over %0d debounce settings",
               samples_sent, events_seen, settings_used + 1);
      $display("requests held back by a full pipe for %0d cycles", req_stall_cycles);
      if (error_count == 0) begin
         $display("key_matrix_debounce_scanner: match");
      end else begin
         $display("key_matrix_debounce_scanner: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/kmd_pkg.sv
sv/kmd_row_mem.sv
sv/kmd_emit.sv
sv/key_matrix_debounce_scanner.sv
tb/sv/tb.sv
